>>> rtl/core/json_string_unescape_utf8_unit_defines.svh
// Assertion macros shared by the JSON string unescaper RTL.
`ifndef JSON_STRING_UNESCAPE_UTF8_UNIT_DEFINES_SVH
`define JSON_STRING_UNESCAPE_UTF8_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// expr must hold at every clock edge out of reset
`define JSU_ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("jsu: invariant violated");

// cons must hold in the same cycle as ante
`define JSU_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("jsu: implication violated");

// cons must hold in the cycle after ante
`define JSU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("jsu: next-cycle check violated");

`else

`define JSU_ASSERT_ALWAYS(label, expr)
`define JSU_ASSERT_SAME(label, ante, cons)
`define JSU_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> rtl/core/jsu_pkg.sv
// Types, constants and decode functions for the JSON string unescaper.
package jsu_pkg;

  localparam int MAX_RES         = 6;
  localparam int RES_IDX_W       = $clog2(MAX_RES);
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [15:0] HIGH_LO = 16'hD800;
  localparam logic [15:0] HIGH_HI = 16'hDBFF;
  localparam logic [15:0] LOW_LO  = 16'hDC00;
  localparam logic [15:0] LOW_HI  = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE = 21'h10000;

  localparam logic [20:0] CP_1B_LIMIT = 21'h00080;
  localparam logic [20:0] CP_2B_LIMIT = 21'h00800;
  localparam logic [20:0] CP_3B_LIMIT = 21'h10000;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DIG0   = 8'h30;
  localparam logic [7:0] CH_DIG9   = 8'h39;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_F  = 8'h66;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_F   = 8'h46;

  localparam logic [7:0] ESC_B = 8'h62;
  localparam logic [7:0] ESC_F = 8'h66;
  localparam logic [7:0] ESC_N = 8'h6E;
  localparam logic [7:0] ESC_R = 8'h72;
  localparam logic [7:0] ESC_T = 8'h74;
  localparam logic [7:0] ESC_U = 8'h75;

  localparam logic [7:0] CTL_BS = 8'h08;
  localparam logic [7:0] CTL_FF = 8'h0C;
  localparam logic [7:0] CTL_LF = 8'h0A;
  localparam logic [7:0] CTL_CR = 8'h0D;
  localparam logic [7:0] CTL_HT = 8'h09;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_STR      = 3'd1,
    PH_ESC      = 3'd2,
    PH_HEX1     = 3'd3,
    PH_HIGH     = 3'd4,
    PH_HIGH_ESC = 3'd5,
    PH_HEX2     = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_END  = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ACT_NONE  = 3'd0,
    ACT_PLAIN = 3'd1,
    ACT_ESC   = 3'd2,
    ACT_CODE  = 3'd3,
    ACT_PAIR  = 3'd4,
    ACT_FAIL  = 3'd5
  } act_t;

  typedef struct packed {
    logic [2:0]      len;
    logic [3:0][7:0] b;
  } utf8_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  typedef struct packed {
    logic       ok;
    logic       is_u;
    logic [7:0] b;
  } esc_t;

  // all results caused by one input byte; only the last one may be non-data
  typedef struct packed {
    logic [MAX_RES-1:0][7:0] b;
    logic [RES_IDX_W-1:0]    cnt;
    kind_t                   tail;
  } rec_t;

  function automatic utf8_t utf8_enc(input logic [20:0] cp);
    utf8_t r;
    r.b = '0;
    if (cp < CP_1B_LIMIT) begin
      r.len  = 3'd1;
      r.b[0] = cp[7:0];
    end else if (cp < CP_2B_LIMIT) begin
      r.len  = 3'd2;
      r.b[0] = {3'b110, cp[10:6]};
      r.b[1] = {2'b10, cp[5:0]};
    end else if (cp < CP_3B_LIMIT) begin
      r.len  = 3'd3;
      r.b[0] = {4'b1110, cp[15:12]};
      r.b[1] = {2'b10, cp[11:6]};
      r.b[2] = {2'b10, cp[5:0]};
    end else begin
      r.len  = 3'd4;
      r.b[0] = {5'b11110, cp[20:18]};
      r.b[1] = {2'b10, cp[17:12]};
      r.b[2] = {2'b10, cp[11:6]};
      r.b[3] = {2'b10, cp[5:0]};
    end
    return r;
  endfunction

  function automatic hex_t hex_dec(input logic [7:0] c);
    hex_t       r;
    logic [7:0] t;
    r.ok = 1'b1;
    t    = 8'h00;
    if (c >= CH_DIG0 && c <= CH_DIG9) begin
      t = c - CH_DIG0;
    end else if (c >= CH_LOW_A && c <= CH_LOW_F) begin
      t = c - CH_LOW_A + 8'd10;
    end else if (c >= CH_UP_A && c <= CH_UP_F) begin
      t = c - CH_UP_A + 8'd10;
    end else begin
      r.ok = 1'b0;
    end
    r.val = t[3:0];
    return r;
  endfunction

  function automatic esc_t esc_map(input logic [7:0] c);
    esc_t r;
    r.ok   = 1'b1;
    r.is_u = 1'b0;
    r.b    = c;
    unique case (c)
      CH_QUOTE, CH_BSLASH, CH_SLASH: r.b = c;
      ESC_B: r.b = CTL_BS;
      ESC_F: r.b = CTL_FF;
      ESC_N: r.b = CTL_LF;
      ESC_R: r.b = CTL_CR;
      ESC_T: r.b = CTL_HT;
      ESC_U: r.is_u = 1'b1;
      default: r.ok = 1'b0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/core/jsu_in_if.sv
// Input byte channel: valid/ready handshake carrying one JSON text byte.
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

>>> rtl/core/jsu_out_if.sv
// Result channel: valid/ready handshake carrying one decoded result.
interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic       last;

  modport source (output valid, output out_byte, output kind, output last, input ready);
  modport sink   (input valid, input out_byte, input kind, input last, output ready);
endinterface

>>> rtl/core/jsu_front.sv
// Front end: accepts text bytes, runs the unescape state machine, builds result records.
`include "json_string_unescape_utf8_unit_defines.svh"

module jsu_front (
  input  logic           clk,
  input  logic           rst,
  jsu_in_if.sink         in_ch,
  input  logic           q_ready,
  output logic           rec_valid,
  output jsu_pkg::rec_t  rec
);
  import jsu_pkg::*;

  phase_t      phase, phase_next;
  logic [1:0]  hex_count, hex_count_next;
  logic [15:0] hex_accum, hex_accum_next;
  logic [15:0] pending_high, pending_high_next;

  logic        accept;
  act_t        act;
  logic        flush;
  hex_t        hx;
  esc_t        es;
  logic [15:0] accum_shift;
  logic        acc_is_high;
  logic        acc_is_low;
  logic [20:0] pair_cp;
  utf8_t       u_hi;
  utf8_t       u_main;
  logic        put_one;
  logic [7:0]  one_byte;
  logic        put_main;
  kind_t       tail;
  logic        go_idle;
  logic [7:0][7:0] rb;
  logic [2:0]  n;

  assign in_ch.ready = q_ready && !rst;
  assign accept      = in_ch.valid && in_ch.ready;

  assign hx          = hex_dec(in_ch.in_byte);
  assign es          = esc_map(in_ch.in_byte);
  assign accum_shift = {hex_accum[11:0], hx.val};
  assign acc_is_high = (accum_shift >= HIGH_LO) && (accum_shift <= HIGH_HI);
  assign acc_is_low  = (accum_shift >= LOW_LO) && (accum_shift <= LOW_HI);
  assign pair_cp     = SUPP_BASE + {1'b0, pending_high[9:0], accum_shift[9:0]};
  assign u_hi        = utf8_enc({5'd0, pending_high});
  assign u_main      = utf8_enc((act == ACT_PAIR) ? pair_cp : {5'd0, accum_shift});

  // classify the byte against the current phase
  always_comb begin
    act   = ACT_NONE;
    flush = 1'b0;
    unique case (phase)
      PH_IDLE: begin
        if (in_ch.in_byte != CH_QUOTE) act = ACT_FAIL;
      end
      PH_STR: act = ACT_PLAIN;
      PH_ESC: act = ACT_ESC;
      PH_HEX1, PH_HEX2: begin
        if (!hx.ok) begin
          flush = (phase == PH_HEX2);
          act   = ACT_FAIL;
        end else if (hex_count == 2'd3) begin
          if (phase == PH_HEX1) begin
            act = ACT_CODE;
          end else if (acc_is_low) begin
            act = ACT_PAIR;
          end else begin
            // held high not followed by a low: emit it, then treat as fresh escape
            flush = 1'b1;
            act   = ACT_CODE;
          end
        end
      end
      PH_HIGH: begin
        if (in_ch.in_byte != CH_BSLASH) begin
          flush = 1'b1;
          act   = ACT_PLAIN;
        end
      end
      PH_HIGH_ESC: begin
        if (in_ch.in_byte != ESC_U) begin
          flush = 1'b1;
          act   = ACT_ESC;
        end
      end
      default: act = ACT_FAIL;
    endcase
  end

  // what the chosen action emits
  always_comb begin
    put_one  = 1'b0;
    one_byte = in_ch.in_byte;
    put_main = 1'b0;
    tail     = KIND_DATA;
    go_idle  = 1'b0;
    case (act)
      ACT_PLAIN: begin
        if (in_ch.in_byte == CH_QUOTE) begin
          tail    = KIND_END;
          go_idle = 1'b1;
        end else if (in_ch.in_byte == CH_BSLASH) begin
          put_one = 1'b0;
        end else if (in_ch.in_byte < CH_SPACE) begin
          tail    = KIND_ERR;
          go_idle = 1'b1;
        end else begin
          put_one = 1'b1;
        end
      end
      ACT_ESC: begin
        if (!es.is_u) begin
          if (!es.ok) begin
            tail    = KIND_ERR;
            go_idle = 1'b1;
          end else begin
            put_one  = 1'b1;
            one_byte = es.b;
          end
        end
      end
      ACT_CODE: put_main = !acc_is_high;
      ACT_PAIR: put_main = 1'b1;
      ACT_FAIL: begin
        tail    = KIND_ERR;
        go_idle = 1'b1;
      end
      default: put_main = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    phase_next        = phase;
    hex_count_next    = hex_count;
    hex_accum_next    = hex_accum;
    pending_high_next = pending_high;
    if (go_idle) begin
      phase_next        = PH_IDLE;
      hex_count_next    = '0;
      hex_accum_next    = '0;
      pending_high_next = '0;
    end else begin
      unique case (act)
        ACT_NONE: begin
          unique case (phase)
            PH_IDLE: phase_next = PH_STR;
            PH_HEX1, PH_HEX2: begin
              hex_count_next = hex_count + 2'd1;
              hex_accum_next = accum_shift;
            end
            PH_HIGH: phase_next = PH_HIGH_ESC;
            PH_HIGH_ESC: begin
              phase_next     = PH_HEX2;
              hex_count_next = '0;
              hex_accum_next = '0;
            end
            default: phase_next = phase;
          endcase
        end
        ACT_PLAIN: begin
          pending_high_next = '0;
          phase_next = (in_ch.in_byte == CH_BSLASH) ? PH_ESC : PH_STR;
        end
        ACT_ESC: begin
          pending_high_next = '0;
          if (es.is_u) begin
            phase_next     = PH_HEX1;
            hex_count_next = '0;
            hex_accum_next = '0;
          end else begin
            phase_next = PH_STR;
          end
        end
        ACT_CODE: begin
          hex_count_next = '0;
          hex_accum_next = '0;
          if (acc_is_high) begin
            pending_high_next = accum_shift;
            phase_next        = PH_HIGH;
          end else begin
            pending_high_next = '0;
            phase_next        = PH_STR;
          end
        end
        ACT_PAIR: begin
          pending_high_next = '0;
          hex_count_next    = '0;
          hex_accum_next    = '0;
          phase_next        = PH_STR;
        end
        default: phase_next = phase;
      endcase
    end
  end

  // pack results: held high first, then the main value, then a single byte or tail
  always_comb begin
    rb = '0;
    n  = '0;
    if (flush) begin
      for (int i = 0; i < 3; i++) rb[3'(i)] = u_hi.b[i];
      n = 3'd3;
    end
    if (put_main) begin
      for (int i = 0; i < 4; i++) begin
        if (3'(i) < u_main.len) rb[3'(n + 3'(i))] = u_main.b[i];
      end
      n = n + u_main.len;
    end
    if (put_one) begin
      rb[n] = one_byte;
      n     = n + 3'd1;
    end
    if (tail != KIND_DATA) begin
      rb[n] = 8'h00;
      n     = n + 3'd1;
    end
    rec.b     = rb[MAX_RES-1:0];
    rec.cnt   = n;
    rec.tail  = tail;
    rec_valid = accept && (n != 3'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      hex_count    <= '0;
      hex_accum    <= '0;
      pending_high <= '0;
    end else if (accept) begin
      phase        <= phase_next;
      hex_count    <= hex_count_next;
      hex_accum    <= hex_accum_next;
      pending_high <= pending_high_next;
    end
  end

  `JSU_ASSERT_SAME(a_idle_clean, phase == PH_IDLE,
    (pending_high == '0) && (hex_count == '0) && (hex_accum == '0))
  `JSU_ASSERT_SAME(a_held_is_high,
    (phase == PH_HIGH) || (phase == PH_HIGH_ESC) || (phase == PH_HEX2),
    (pending_high >= HIGH_LO) && (pending_high <= HIGH_HI))
  `JSU_ASSERT_NEXT(a_idle_error_stays,
    accept && (phase == PH_IDLE) && (in_ch.in_byte != CH_QUOTE), phase == PH_IDLE)

endmodule

>>> rtl/core/jsu_queue.sv
// Record queue between the front end and the serializer.
`include "json_string_unescape_utf8_unit_defines.svh"

module jsu_queue #(
  parameter int DEPTH = jsu_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  jsu_pkg::rec_t  rec_in,
  output logic           ready,
  input  logic           pop,
  output logic           valid,
  output jsu_pkg::rec_t  head
);
  import jsu_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rec_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] cnt;

  assign ready = (cnt != CNT_W'(DEPTH));
  assign valid = (cnt != '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= rec_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

  `JSU_ASSERT_ALWAYS(a_cnt_bound, cnt <= CNT_W'(DEPTH))
  `JSU_ASSERT_SAME(a_no_overflow, push, cnt != CNT_W'(DEPTH))
  `JSU_ASSERT_NEXT(a_push_grows, push && !pop, cnt == $past(cnt) + 1'b1)

endmodule

>>> rtl/core/jsu_back.sv
// Back end: walks the head record and presents one result per transaction.
module jsu_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  jsu_pkg::rec_t  head,
  output logic           pop,
  jsu_out_if.source      out_ch
);
  import jsu_pkg::*;

  logic [RES_IDX_W-1:0] idx;
  logic                 is_last;
  logic                 accept;

  assign is_last = (idx == head.cnt - 1'b1);
  assign accept  = out_ch.valid && out_ch.ready;
  assign pop     = accept && is_last;

  assign out_ch.valid    = q_valid;
  assign out_ch.out_byte = head.b[idx];
  assign out_ch.kind     = is_last ? head.tail : KIND_DATA;
  assign out_ch.last     = is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (accept) begin
      idx <= is_last ? '0 : idx + 1'b1;
    end
  end

endmodule

>>> rtl/core/json_string_unescape_utf8_unit.sv
// Top level of the JSON string unescaper with UTF-8 output.
// in_ch takes one byte of JSON text per transaction (valid/ready). out_ch
// gives results one per transaction: out_byte with kind 0 is a decoded UTF-8
// byte, kind 1 marks a closing quote, kind 2 a syntax error; last flags the
// final result caused by an input byte. A byte may cause no result (opening
// quote, backslash, hex digits) or up to six (a held high surrogate flushed
// ahead of the next value).
// A byte's records enter the queue when it is accepted; its first result
// is offered from the queue head. Throughput, while out_ch.ready is high:
// one result out per cycle, and one input byte per cycle while each byte
// yields at most one result; a byte with k results takes k transactions.
// A queue of QUEUE_DEPTH per-byte records between decoder and serializer
// absorbs those bursts; in_ch.ready drops only when it is full or in
// reset. When the receiver stalls, the current result holds and the queue
// fills; the decoder keeps accepting until then.
// Reset (rst, synchronous) returns the decoder to idle outside any string,
// empties the queue and holds in_ch.ready low while asserted.
module json_string_unescape_utf8_unit #(
  parameter int QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  jsu_in_if.sink    in_ch,
  jsu_out_if.source out_ch
);
  import jsu_pkg::*;

  logic rec_valid;
  rec_t rec;
  logic q_ready;
  logic q_valid;
  rec_t head;
  logic pop;

  jsu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .q_ready   (q_ready),
    .rec_valid (rec_valid),
    .rec       (rec)
  );

  jsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (rec_valid),
    .rec_in (rec),
    .ready  (q_ready),
    .pop    (pop),
    .valid  (q_valid),
    .head   (head)
  );

  jsu_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .head    (head),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

>>> dv/tb_json_string_unescape_utf8_unit.sv
// Self-checking testbench for the JSON string unescaper with UTF-8 output.
module tb_json_string_unescape_utf8_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import jsu_pkg::*;

  localparam int TEXT_ITEMS = 450;
  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_CYCLES = 20;

  typedef enum int {RX_OPEN, RX_BUSY, RX_CHOKED, RX_STRIPED} rx_mode_t;

  // Tracks the decoder state and the results each accepted byte must produce.
  class unescape_scoreboard;
    typedef struct packed {
      logic [7:0] data;
      kind_t      kind;
      logic       last;
    } result_t;

    phase_t      phase;
    logic [1:0]  hex_count;
    logic [15:0] hex_accum;
    logic [15:0] pending_high;
    result_t     expected_q[$];
    int          errors;

    function new();
      errors = 0;
      clear_state();
    endfunction

    function void clear_state();
      phase        = PH_IDLE;
      hex_count    = 2'd0;
      hex_accum    = 16'h0000;
      pending_high = 16'h0000;
    endfunction

    function void push(logic [7:0] data, kind_t kind);
      result_t r;
      r.data = data;
      r.kind = kind;
      r.last = 1'b0;
      expected_q.insert(expected_q.size(), r);
    endfunction

    function void push_utf8(logic [20:0] cp);
      if (cp < 21'h80) begin
        push(cp[7:0], KIND_DATA);
      end else if (cp < 21'h800) begin
        push(8'hC0 | 8'(cp >> 6), KIND_DATA);
        push(8'h80 | 8'(cp & 21'h3F), KIND_DATA);
      end else if (cp < 21'h10000) begin
        push(8'hE0 | 8'(cp >> 12), KIND_DATA);
        push(8'h80 | 8'((cp >> 6) & 21'h3F), KIND_DATA);
        push(8'h80 | 8'(cp & 21'h3F), KIND_DATA);
      end else begin
        push(8'hF0 | 8'((cp >> 18) & 21'h07), KIND_DATA);
        push(8'h80 | 8'((cp >> 12) & 21'h3F), KIND_DATA);
        push(8'h80 | 8'((cp >> 6) & 21'h3F), KIND_DATA);
        push(8'h80 | 8'(cp & 21'h3F), KIND_DATA);
      end
    endfunction

    function void fail_byte();
      push(8'h00, KIND_ERR);
      clear_state();
    endfunction

    function void flush_high();
      push_utf8({5'd0, pending_high});
      pending_high = 16'h0000;
    endfunction

    function int digit_of(logic [7:0] c);
      if (c >= CH_DIG0 && c <= CH_DIG9) return int'(c - CH_DIG0);
      if (c >= CH_LOW_A && c <= CH_LOW_F) return int'(c - CH_LOW_A) + 10;
      if (c >= CH_UP_A && c <= CH_UP_F) return int'(c - CH_UP_A) + 10;
      return -1;
    endfunction

    function void string_char(logic [7:0] c);
      if (c == CH_QUOTE) begin
        push(8'h00, KIND_END);
        clear_state();
      end else if (c == CH_BSLASH) begin
        phase = PH_ESC;
      end else if (c < CH_SPACE) begin
        fail_byte();
      end else begin
        push(c, KIND_DATA);
        phase = PH_STR;
      end
    endfunction

    function void escape_char(logic [7:0] c);
      logic [7:0] m;
      case (c)
        CH_QUOTE, CH_BSLASH, CH_SLASH: m = c;
        ESC_B: m = CTL_BS;
        ESC_F: m = CTL_FF;
        ESC_N: m = CTL_LF;
        ESC_R: m = CTL_CR;
        ESC_T: m = CTL_HT;
        ESC_U: begin
          phase     = PH_HEX1;
          hex_count = 2'd0;
          hex_accum = 16'h0000;
          return;
        end
        default: begin
          fail_byte();
          return;
        end
      endcase
      push(m, KIND_DATA);
      phase = PH_STR;
    endfunction

    // a high surrogate is held until the following bytes show whether a pair follows
    function void take_code(logic [15:0] code);
      hex_count = 2'd0;
      hex_accum = 16'h0000;
      if (code >= HIGH_LO && code <= HIGH_HI) begin
        pending_high = code;
        phase        = PH_HIGH;
      end else begin
        push_utf8({5'd0, code});
        phase = PH_STR;
      end
    endfunction

    function void note_byte(logic [7:0] c);
      int          d;
      int          base;
      logic [15:0] code;
      result_t     r;
      base = expected_q.size();
      case (phase)
        PH_STR: string_char(c);
        PH_ESC: escape_char(c);
        PH_HEX1, PH_HEX2: begin
          d = digit_of(c);
          if (d < 0) begin
            if (phase == PH_HEX2) flush_high();
            fail_byte();
          end else begin
            hex_accum = {hex_accum[11:0], 4'(d)};
            if (hex_count < 2'd3) begin
              hex_count++;
            end else if (phase == PH_HEX1) begin
              take_code(hex_accum);
            end else if (hex_accum >= LOW_LO && hex_accum <= LOW_HI) begin
              push_utf8(SUPP_BASE + {1'b0, pending_high[9:0], hex_accum[9:0]});
              pending_high = 16'h0000;
              hex_count    = 2'd0;
              hex_accum    = 16'h0000;
              phase        = PH_STR;
            end else begin
              code = hex_accum;
              flush_high();
              take_code(code);
            end
          end
        end
        PH_HIGH: begin
          if (c == CH_BSLASH) begin
            phase = PH_HIGH_ESC;
          end else begin
            flush_high();
            phase = PH_STR;
            string_char(c);
          end
        end
        PH_HIGH_ESC: begin
          if (c == ESC_U) begin
            phase     = PH_HEX2;
            hex_count = 2'd0;
            hex_accum = 16'h0000;
          end else begin
            flush_high();
            phase = PH_STR;
            escape_char(c);
          end
        end
        default: begin
          if (c == CH_QUOTE) begin
            clear_state();
            phase = PH_STR;
          end else begin
            fail_byte();
          end
        end
      endcase
      if (expected_q.size() > base) begin
        r      = expected_q[expected_q.size() - 1];
        r.last = 1'b1;
        expected_q[expected_q.size() - 1] = r;
      end
    endfunction

    function void check_result(logic [7:0] data, logic [1:0] kind, logic last);
      result_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: result with none pending: out_byte %02h kind %0d last %0b",
                 $time, data, kind, last);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (data !== e.data) begin
        $display("%0t: out_byte expected %02h, got %02h", $time, e.data, data);
        errors++;
      end
      if (kind !== e.kind) begin
        $display("%0t: kind expected %0d, got %0d", $time, e.kind, kind);
        errors++;
      end
      if (last !== e.last) begin
        $display("%0t: last expected %0b, got %0b", $time, e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  jsu_in_if  in_ch();
  jsu_out_if out_ch();

  json_string_unescape_utf8_unit dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  unescape_scoreboard sb;
  logic [7:0]         text_q[$];
  int                 cycle_cnt;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic void add(logic [7:0] c);
    text_q.insert(text_q.size(), c);
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return CH_DIG0 + 8'(n);
    return ($urandom_range(0, 1) ? CH_UP_A : CH_LOW_A) + 8'(n) - 8'd10;
  endfunction

  function automatic void add_u(logic [15:0] code);
    add(CH_BSLASH);
    add(ESC_U);
    for (int i = 3; i >= 0; i--) add(hex_char(code[i*4 +: 4]));
  endfunction

  function automatic bit is_hex(logic [7:0] c);
    return (c >= CH_DIG0 && c <= CH_DIG9) || (c >= CH_LOW_A && c <= CH_LOW_F) ||
           (c >= CH_UP_A && c <= CH_UP_F);
  endfunction

  function automatic bit is_escape(logic [7:0] c);
    case (c)
      CH_QUOTE, CH_BSLASH, CH_SLASH, ESC_B, ESC_F, ESC_N, ESC_R, ESC_T, ESC_U: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(32, 255));
    while (c == CH_QUOTE || c == CH_BSLASH);
    return c;
  endfunction

  function automatic logic [15:0] rand_code();
    case ($urandom_range(0, 6))
      0:       return 16'($urandom_range(0, 16'h7F));
      1:       return 16'($urandom_range(16'h80, 16'h7FF));
      2:       return 16'($urandom_range(16'h800, 16'hD7FF));
      3:       return 16'($urandom_range(16'hE000, 16'hFFFF));
      4:       return 16'($urandom_range(HIGH_LO, HIGH_HI));
      5:       return 16'($urandom_range(LOW_LO, LOW_HI));
      default: return 16'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  // \u with some good digits then a non-hex byte
  function automatic void add_bad_hex();
    int         good;
    logic [7:0] c;
    good = $urandom_range(0, 3);
    add(CH_BSLASH);
    add(ESC_U);
    repeat (good) add(hex_char(4'($urandom_range(0, 15))));
    do c = 8'($urandom_range(0, 255));
    while (is_hex(c));
    add(c);
  endfunction

  // an error ends the string; the decoder is back to idle afterwards
  function automatic void add_broken_tail();
    logic [7:0] c;
    case ($urandom_range(0, 3))
      0: add(8'($urandom_range(0, 31)));
      1: begin
        do c = 8'($urandom_range(0, 255));
        while (is_escape(c));
        add(CH_BSLASH);
        add(c);
      end
      2: add_bad_hex();
      default: begin
        add_u(16'($urandom_range(HIGH_LO, HIGH_HI)));
        add_bad_hex();
      end
    endcase
  endfunction

  function automatic void add_string();
    int         segs;
    logic [7:0] c;
    if ($urandom_range(0, 19) == 0) begin
      do c = 8'($urandom_range(0, 255));
      while (c == CH_QUOTE);
      add(c);
    end
    add(CH_QUOTE);
    segs = $urandom_range(0, 8);
    for (int i = 0; i < segs; i++) begin
      if ($urandom_range(0, 99) < 4) begin
        add_broken_tail();
        return;
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3: add(plain_char());
        4, 5: begin
          do c = 8'($urandom_range(0, 255));
          while (!is_escape(c) || c == ESC_U);
          add(CH_BSLASH);
          add(c);
        end
        6, 7, 8: add_u(rand_code());
        default: begin
          add_u(16'($urandom_range(HIGH_LO, HIGH_HI)));
          add_u(16'($urandom_range(LOW_LO, LOW_HI)));
        end
      endcase
    end
    add(CH_QUOTE);
  endfunction

  task automatic send_text();
    int         burst;
    int         gap;
    logic [7:0] c;
    @(negedge clk);
    while (text_q.size() > 0) begin
      burst = $urandom_range(1, 24);
      gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      while (burst > 0 && text_q.size() > 0) begin
        c = text_q.pop_front();
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= c;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        sb.note_byte(c);
        @(negedge clk);
        burst--;
      end
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_ch.valid <= 1'b0;
  endtask

  // receiver backpressure: a mode drawn at random holds for a random span
  initial begin
    rx_mode_t mode;
    int       span;
    out_ch.ready = 1'b0;
    forever begin
      mode = rx_mode_t'($urandom_range(0, 3));
      span = $urandom_range(32, 200);
      for (int i = 0; i < span; i++) begin
        @(negedge clk);
        case (mode)
          RX_OPEN:   out_ch.ready <= 1'b1;
          RX_BUSY:   out_ch.ready <= ($urandom_range(0, 9) < 7);
          RX_CHOKED: out_ch.ready <= ($urandom_range(0, 3) == 0);
          default:   out_ch.ready <= ((i % 16) >= 11);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      sb.check_result(out_ch.out_byte, out_ch.kind, out_ch.last);
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("json_string_unescape_utf8_unit: mismatch");
    $finish;
  end

  initial begin
    int directed_len;
    rst           = 1'b1;
    in_ch.valid   = 1'b0;
    in_ch.in_byte = 8'h00;
    sb            = new();

    // stray byte while idle, then a pair at the top of the code space
    add(8'h61);
    add(CH_QUOTE);
    add(CH_SPACE);
    add(8'hFF);
    add_u(16'hDBFF);
    add_u(16'hDFFF);
    add(CH_QUOTE);
    // NUL inside a string, unknown escape, \u0000
    add(CH_QUOTE);
    add(8'h00);
    add(CH_QUOTE);
    add(CH_BSLASH);
    add(8'h71);
    add(CH_QUOTE);
    add_u(16'h0000);
    add(CH_QUOTE);

    directed_len = text_q.size();
    while (text_q.size() < directed_len + TEXT_ITEMS) add_string();

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_text();
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("json_string_unescape_utf8_unit: match");
    end else begin
      $display("json_string_unescape_utf8_unit: mismatch");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/jsu_pkg.sv
rtl/core/jsu_in_if.sv
rtl/core/jsu_out_if.sv
rtl/core/jsu_front.sv
rtl/core/jsu_queue.sv
rtl/core/jsu_back.sv
rtl/core/json_string_unescape_utf8_unit.sv
dv/tb_json_string_unescape_utf8_unit.sv
